>>> design/mmq_pkg.sv
// shared types and constants for the multicast message queue
`timescale 1ns / 1ps
package mmq_pkg;
  localparam int Depth = 16;
  localparam int MaxSubs = 8;
  localparam int PayW = 32;
  localparam int IdW = 16;
  localparam int PtrW = $clog2(Depth) + 1;
  localparam int SlotW = $clog2(Depth);
  localparam int SubW = $clog2(MaxSubs);
  localparam int CntW = $clog2(Depth + 1);
  localparam int RcvW = $clog2(MaxSubs + 1);
  localparam int SubCntW = $clog2(MaxSubs + 1);
  localparam logic [PtrW-1:0] Nil = PtrW'(Depth);

  typedef enum logic [2:0] {
    OP_SUB = 3'd0, OP_UNSUB = 3'd1, OP_PUB = 3'd2, OP_READ = 3'd3,
    OP_COUNT = 3'd4, OP_REMOVE = 3'd5, OP_NONE6 = 3'd6, OP_NONE7 = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_FULL = 3'd1, ST_EMPTY = 3'd2, ST_NOSUB = 3'd3,
    ST_TFULL = 3'd4, ST_NOTFOUND = 3'd5, ST_DROPPED = 3'd6
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_FIND, S_DISPATCH, S_PUB, S_RD_A, S_RD_B,
    S_UN_WALK, S_UN_DEC, S_CNT, S_RM_SCAN, S_PREV, S_DROP, S_DROP2, S_OUT
  } state_t;

  typedef struct packed {
    logic [2:0] status;
    logic [PayW-1:0] rd;
    logic [CntW-1:0] count;
  } result_t;
endpackage

>>> design/mmq_ram.sv
// generic ram with one write port and one registered read port
`timescale 1ns / 1ps
module mmq_ram #(
  parameter int Width = 8,
  parameter int Entries = 16
) (
  input  logic clk,
  input  logic we,
  input  logic [$clog2(Entries)-1:0] waddr,
  input  logic [Width-1:0] wdata,
  input  logic [$clog2(Entries)-1:0] raddr,
  output logic [Width-1:0] rdata
);
  logic [Width-1:0] mem [Entries];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> design/mmq_ctrl.sv
// sequencer walking the message list one entry per step
`timescale 1ns / 1ps
module mmq_ctrl import mmq_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_go,
  input  logic [2:0] in_op,
  input  logic [IdW-1:0] in_id,
  input  logic [PayW-1:0] in_pay,
  input  logic [4:0] capacity,
  output logic busy,
  output logic res_valid,
  input  logic res_take,
  output result_t res
);
  state_t state, state_next;
  logic [2:0] op;
  logic [IdW-1:0] id;
  logic [PayW-1:0] pay;
  logic sub_valid [MaxSubs];
  logic [IdW-1:0] sub_id [MaxSubs];
  logic [PtrW-1:0] sub_nu [MaxSubs];
  logic [PtrW-1:0] link [Depth];
  logic [RcvW-1:0] rcv [Depth];
  logic [PtrW-1:0] head, tail, free_head;
  logic [CntW-1:0] msg_total;
  logic [SubCntW-1:0] sub_total;
  logic [SubW:0] scan;
  logic found;
  logic [SubW-1:0] sidx;
  logic [PtrW-1:0] cur, prev, start, hit, nxt_after;
  logic claim, return_unsub;
  logic [CntW-1:0] cnt;
  logic [2:0] status;
  logic [PayW-1:0] rd;
  logic we;
  logic [SlotW-1:0] waddr, raddr;
  logic [PayW-1:0] wdata, rdata;
  logic [CntW-1:0] cap;
  logic [SubW-1:0] free_sub;
  logic free_any;

  mmq_ram #(.Width(PayW), .Entries(Depth)) u_words (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  assign cap = (capacity > 5'(Depth)) ? CntW'(Depth) : CntW'(capacity);
  assign busy = (state != S_IDLE);
  assign res_valid = (state == S_OUT);
  assign res.status = status;
  assign res.rd = rd;
  assign res.count = (op == OP_COUNT) ? cnt : '0;
  assign we = (state == S_PUB) && (msg_total < cap) && (free_head != Nil)
    && (sub_total != 0);
  assign waddr = free_head[SlotW-1:0];
  assign wdata = pay;

  always_comb begin
    free_sub = '0;
    free_any = 1'b0;
    for (int i = MaxSubs - 1; i >= 0; i--) begin
      if (!sub_valid[i]) begin
        free_sub = SubW'(i);
        free_any = 1'b1;
      end
    end
  end

  always_comb begin
    raddr = cur[SlotW-1:0];
    state_next = state;
    case (state)
      S_IDLE: if (in_go) state_next = S_FIND;
      S_FIND: if (scan[SubW] || found) state_next = S_DISPATCH;
      S_DISPATCH: begin
        state_next = S_OUT;
        case (op)
          OP_UNSUB: if (found) state_next = S_UN_WALK;
          OP_PUB: state_next = S_PUB;
          OP_READ: if (found && sub_nu[sidx] != Nil) state_next = S_RD_A;
          OP_COUNT: if (found) state_next = S_CNT;
          OP_REMOVE: if (head != Nil && tail != Nil) state_next = S_RM_SCAN;
          default: ;
        endcase
      end
      S_PUB: state_next = S_OUT;
      S_RD_A: state_next = S_RD_B;
      S_RD_B: state_next = (rcv[cur[SlotW-1:0]] > 1) ? S_OUT : S_PREV;
      S_CNT: if (!(cnt < CntW'(Depth) && cur != Nil)) state_next = S_OUT;
      S_UN_WALK: begin
        if (cnt < CntW'(Depth) && cur != Nil && start != Nil) begin
          if (cur == start || claim) state_next = S_UN_DEC;
        end else state_next = S_OUT;
      end
      S_UN_DEC: state_next = (rcv[cur[SlotW-1:0]] > 1) ? S_UN_WALK : S_DROP;
      S_RM_SCAN: begin
        if (cnt >= CntW'(4) && (cur == Nil || hit >= Nil)) state_next = S_OUT;
        else if (cnt != CntW'(0) && cnt != CntW'(2) && cnt != CntW'(4) && rdata == pay)
          state_next = S_PREV;
      end
      S_PREV: if (start == hit || start == Nil || cnt >= CntW'(Depth)) state_next = S_DROP;
      S_DROP: state_next = S_DROP2;
      S_DROP2: state_next = return_unsub ? S_UN_WALK : S_OUT;
      S_OUT: if (res_take) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MaxSubs; i++) begin
        sub_valid[i] <= 1'b0;
        sub_nu[i] <= Nil;
      end
      for (int s = 0; s < Depth; s++) begin
        link[s] <= PtrW'(s + 1);
        rcv[s] <= '0;
      end
      head <= Nil;
      tail <= Nil;
      free_head <= '0;
      msg_total <= '0;
      sub_total <= '0;
    end else begin
      case (state)
        S_IDLE: if (in_go) begin
          op <= in_op; id <= in_id; pay <= in_pay;
          scan <= '0; found <= 1'b0; status <= ST_OK; rd <= '0; cnt <= '0;
        end
        S_FIND: begin
          if (!(scan[SubW] || found)) begin
            if (sub_valid[scan[SubW-1:0]] && sub_id[scan[SubW-1:0]] == id) begin
              found <= 1'b1;
              sidx <= scan[SubW-1:0];
            end
            scan <= scan + 1'b1;
          end
        end
        S_DISPATCH: begin
          case (op)
            OP_SUB: if (free_any) begin
              sub_valid[free_sub] <= 1'b1;
              sub_id[free_sub] <= id;
              sub_nu[free_sub] <= Nil;
              sub_total <= sub_total + 1'b1;
            end else status <= ST_TFULL;
            OP_UNSUB: if (!found) status <= ST_NOSUB;
            else begin
              start <= sub_nu[sidx];
              sub_valid[sidx] <= 1'b0;
              sub_nu[sidx] <= Nil;
              sub_total <= sub_total - 1'b1;
              prev <= Nil; cur <= head; claim <= 1'b0; cnt <= '0;
            end
            OP_READ: if (!found) status <= ST_NOSUB;
            else if (sub_nu[sidx] == Nil) status <= ST_EMPTY;
            else cur <= sub_nu[sidx];
            OP_COUNT: if (!found) status <= ST_NOSUB;
            else cur <= sub_nu[sidx];
            OP_REMOVE: if (head == Nil || tail == Nil) status <= ST_NOTFOUND;
            else begin
              cur <= head; cnt <= '0; hit <= Nil;
            end
            default: ;
          endcase
        end
        S_PUB: begin
          if (msg_total >= cap || free_head == Nil) status <= ST_FULL;
          else if (sub_total == 0) status <= ST_DROPPED;
          else begin
            free_head <= link[free_head[SlotW-1:0]];
            rcv[free_head[SlotW-1:0]] <= RcvW'(sub_total);
            link[free_head[SlotW-1:0]] <= Nil;
            if (tail != Nil) link[tail[SlotW-1:0]] <= free_head;
            tail <= free_head;
            if (head == Nil) head <= free_head;
            msg_total <= msg_total + 1'b1;
            for (int i = 0; i < MaxSubs; i++)
              if (sub_valid[i] && sub_nu[i] == Nil) sub_nu[i] <= free_head;
          end
        end
        S_RD_B: begin
          rd <= rdata;
          sub_nu[sidx] <= link[cur[SlotW-1:0]];
          if (rcv[cur[SlotW-1:0]] > 1) begin
            rcv[cur[SlotW-1:0]] <= rcv[cur[SlotW-1:0]] - 1'b1;
          end else begin
            rcv[cur[SlotW-1:0]] <= '0;
            hit <= cur; prev <= Nil; start <= head; cnt <= '0;
            return_unsub <= 1'b0;
          end
        end
        S_CNT: begin
          if (cnt < CntW'(Depth) && cur != Nil) begin
            cnt <= cnt + 1'b1;
            cur <= link[cur[SlotW-1:0]];
          end
        end
        S_UN_WALK: begin
          if (cnt < CntW'(Depth) && cur != Nil && start != Nil) begin
            cnt <= cnt + 1'b1;
            nxt_after <= link[cur[SlotW-1:0]];
            if (cur == start || claim) begin
              claim <= 1'b1;
            end else begin
              prev <= cur;
              cur <= link[cur[SlotW-1:0]];
            end
          end else begin
            cnt <= '0;
          end
        end
        S_UN_DEC: begin
          if (rcv[cur[SlotW-1:0]] > 1) begin
            rcv[cur[SlotW-1:0]] <= rcv[cur[SlotW-1:0]] - 1'b1;
            prev <= cur;
            cur <= nxt_after;
          end else begin
            rcv[cur[SlotW-1:0]] <= '0;
            hit <= cur;
            return_unsub <= 1'b1;
          end
        end
        S_RM_SCAN: begin
          // head first, then tail, then the list from the head
          if (cnt == CntW'(0)) begin
            cur <= head; cnt <= CntW'(1);
          end else if (cnt == CntW'(1)) begin
            if (rdata == pay) begin
              hit <= head; prev <= Nil; start <= head;
              cnt <= '0; return_unsub <= 1'b0;
            end else begin
              cur <= tail; cnt <= CntW'(2);
            end
          end else if (cnt == CntW'(2)) begin
            cnt <= CntW'(3);
          end else if (cnt == CntW'(3)) begin
            if (rdata == pay) begin
              hit <= tail; prev <= Nil; start <= head;
              cnt <= '0; return_unsub <= 1'b0;
            end else begin
              cur <= head; cnt <= CntW'(4); hit <= '0;
            end
          end else begin
            // alternate: issue read, then compare
            if (cur == Nil || hit >= Nil) begin
              status <= ST_NOTFOUND;
            end else if (cnt == CntW'(4)) begin
              cnt <= CntW'(5);
            end else begin
              if (rdata == pay) begin
                hit <= cur; prev <= Nil; start <= head;
                cnt <= '0; return_unsub <= 1'b0;
              end else begin
                cur <= link[cur[SlotW-1:0]]; cnt <= CntW'(4);
                hit <= hit + 1'b1;
              end
            end
          end
        end
        S_PREV: begin
          if (start == hit || start == Nil || cnt >= CntW'(Depth)) begin
            if (start != hit) prev <= Nil;
          end else begin
            prev <= start;
            start <= link[start[SlotW-1:0]];
            cnt <= cnt + 1'b1;
          end
        end
        S_DROP: begin
          if (prev == Nil) head <= link[hit[SlotW-1:0]];
          else link[prev[SlotW-1:0]] <= link[hit[SlotW-1:0]];
          if (tail == hit) tail <= prev;
          for (int i = 0; i < MaxSubs; i++)
            if (sub_nu[i] == hit) sub_nu[i] <= link[hit[SlotW-1:0]];
          link[hit[SlotW-1:0]] <= free_head;
          free_head <= hit;
          if (msg_total != 0) msg_total <= msg_total - 1'b1;
        end
        S_DROP2: if (return_unsub) cur <= nxt_after;
        default: ;
      endcase
    end
  end
endmodule

>>> design/multicast_message_queue_unit.sv
// top level of the multicast message queue
//
// slave channel s_axis_* carries one command word: operation, subscriber id
// and payload. master channel m_axis_* returns one result word per command:
// status, read payload and unread count. cfg_* writes the capacity register
// (reset value 16); the user must write it only while the block is idle, the
// block itself does not enforce this. every command first passes through the
// subscriber search. a read that frees its message walks the list for its
// predecessor; count, remove and unsubscribe walk the message list, remove
// comparing payloads through the single word ram read port. one command is
// handled at a time; s_axis_tready is low from acceptance until the cycle
// after the result word is taken.
// reset (rst, synchronous) empties the list, rebuilds the free chain and
// drops all subscribers. a stalled receiver holds the result on m_axis_tdata
// and the block takes no new command until it is taken.
`timescale 1ns / 1ps
module multicast_message_queue_unit import mmq_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  logic [55:0] s_axis_tdata, // operation, subscriber_id, payload
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  output logic [39:0] m_axis_tdata, // status, read_payload, unread_count
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [4:0] cfg_data
);
  logic [4:0] capacity;
  logic busy;
  result_t res;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= 5'd16;
    end else if (cfg_valid) begin
      capacity <= cfg_data;
    end
  end

  assign s_axis_tready = !busy;

  mmq_ctrl u_ctrl (
    .clk, .rst,
    .in_go(s_axis_tvalid && !busy),
    .in_op(s_axis_tdata[2:0]),
    .in_id(s_axis_tdata[18:3]),
    .in_pay(s_axis_tdata[50:19]),
    .capacity,
    .busy,
    .res_valid(m_axis_tvalid),
    .res_take(m_axis_tready),
    .res
  );

  assign m_axis_tdata = {res.count, res.rd, res.status};
endmodule

>>> design/mmq_checker.sv
// port level checks for the multicast message queue
`timescale 1ns / 1ps
module mmq_checker (
  input logic clk,
  input logic rst,
  input logic s_axis_tvalid,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [39:0] m_axis_tdata
);
  a_no_in_while_out: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready) else $error("ready while result pending");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready) else $error("ready after accept");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata)) else $error("result changed");
  a_status: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[2:0] != 3'd7) else $error("bad status");
endmodule

bind multicast_message_queue_unit mmq_checker u_chk (
  .clk, .rst, .s_axis_tvalid, .s_axis_tready, .m_axis_tvalid, .m_axis_tready,
  .m_axis_tdata
);
